@@ design/ppeu_pkg.sv @@
// Shared types, constants and arithmetic helpers for the particle pool update block.
package ppeu_pkg;

    localparam int unsigned PoolDepthDef = 32;
    localparam int unsigned NumPools     = 2;
    localparam int unsigned CfgIdxW      = 3;
    localparam int unsigned CfgDataW     = 32;

    localparam logic [30:0] LifePool0Rst = 31'd13107;
    localparam logic [30:0] LifePool1Rst = 31'd65536;
    localparam logic [31:0] PullY1Rst    = 32'hFFD8_0000;

    typedef enum logic [1:0] {
        REQ_SPAWN   = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_READOUT = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        CFG_LIFE0 = 3'd0,
        CFG_LIFE1 = 3'd1,
        CFG_PX0   = 3'd2,
        CFG_PY0   = 3'd3,
        CFG_PZ0   = 3'd4,
        CFG_PX1   = 3'd5,
        CFG_PY1   = 3'd6,
        CFG_PZ1   = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAWN,
        ST_T_RD,
        ST_T_WAIT,
        ST_T_VEL,
        ST_T_POS,
        ST_T_WR,
        ST_C_RD,
        ST_C_WAIT,
        ST_C_CHK,
        ST_C_CPY,
        ST_R_RD,
        ST_R_WAIT,
        ST_R_OUT,
        ST_RESP
    } t_state;

    // One stored particle: the whole row of the particle memory.
    typedef struct packed {
        logic [31:0] life;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] prev_x;
        logic [31:0] prev_y;
        logic [31:0] prev_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
    } t_part;

    // Saturate a 34-bit signed sum to 32 bits.
    function automatic logic [31:0] sat34(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q16.16 times Q0.16, floored back to Q16.16 (33 bits are enough).
    function automatic logic signed [32:0] mul_dt(input logic [31:0] a,
                                                  input logic [15:0] dt);
        logic signed [48:0] p;
        p = $signed(a) * $signed({1'b0, dt});
        return p[48:16];
    endfunction

endpackage

@@ design/particle_pool_euler_update_top.sv @@
// Top level: sequencer over the particle memory for spawn, tick and readout.
// Spawn, tick or unused code: a single result. Readout: one result per live particle, pool 0
// first (one empty result if both pools are empty). Tick, per pool: each particle is read,
// waited on, stepped (velocity, then position) and written back unless expired; compaction then
// keeps live entries and fills holes from the tail. One item at a time: ready only when idle.
// Reset (synchronous, active low) empties both pools and restores register defaults.
module particle_pool_euler_update_top #(
    parameter int unsigned POOL_DEPTH = ppeu_pkg::PoolDepthDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_req_type,
    input  logic                          i_pool_select,
    input  logic [31:0]                   i_in_pos_x,
    input  logic [31:0]                   i_in_pos_y,
    input  logic [31:0]                   i_in_pos_z,
    input  logic [31:0]                   i_in_vel_x,
    input  logic [31:0]                   i_in_vel_y,
    input  logic [31:0]                   i_in_vel_z,
    input  logic [15:0]                   i_step_time,
    input  logic                          i_cfg_we,
    input  logic [ppeu_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [ppeu_pkg::CfgDataW-1:0] i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_status,
    output logic                          o_out_pool,
    output logic [31:0]                   o_out_pos_x,
    output logic [31:0]                   o_out_pos_y,
    output logic [31:0]                   o_out_pos_z,
    output logic [31:0]                   o_out_prev_x,
    output logic [31:0]                   o_out_prev_y,
    output logic [31:0]                   o_out_prev_z,
    output logic [6:0]                    o_live_count,
    output logic                          o_particle_valid,
    output logic                          o_last
);
    import ppeu_pkg::*;

    // Sizes derived from the pool depth.
    localparam int unsigned IdxW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int unsigned CntW  = $clog2(POOL_DEPTH + 1);
    localparam int unsigned AddrW = IdxW + 1;
    localparam int unsigned Store = 2 * (1 << IdxW);
    localparam int unsigned TotW  = CntW + 1;

    t_state r_state, n_state;

    // Latched item.
    logic        r_pool, n_pool;
    logic [15:0] r_dt;
    t_req        r_req;
    logic [31:0] r_ipx, r_ipy, r_ipz, r_ivx, r_ivy, r_ivz;

    logic [CntW-1:0] r_cnt0, r_cnt1, n_cnt0, n_cnt1;
    logic [CntW-1:0] r_idx, n_idx;   // walk index within a pool
    logic [CntW-1:0] r_n, n_n;       // working count during compaction

    // Dead flags for the tick: one per pool entry, captured as each entry is stepped.
    logic [POOL_DEPTH-1:0] r_dead, n_dead;

    // Particle being processed.
    t_part r_work, n_work;

    // Output register.
    logic        r_ovalid, n_ovalid;
    logic        r_ostatus, n_ostatus;
    logic        r_opool, n_opool;
    logic        r_opv, n_opv;
    logic        r_olast, n_olast;
    logic [31:0] r_opx, r_opy, r_opz, r_oqx, r_oqy, r_oqz;
    logic [31:0] n_opx, n_opy, n_opz, n_oqx, n_oqy, n_oqz;

    // Memory port.
    logic             mem_we;
    logic [AddrW-1:0] mem_waddr, mem_raddr;
    t_part            mem_wdata, mem_rdata;

    logic [31:0] cfg_life, cfg_px, cfg_py, cfg_pz;

    ppeu_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pool     (r_pool),
        .o_life     (cfg_life),
        .o_pull_x   (cfg_px),
        .o_pull_y   (cfg_py),
        .o_pull_z   (cfg_pz)
    );

    ppeu_part_mem #(
        .Depth (Store),
        .AddrW (AddrW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic [CntW-1:0] cur_cnt;
    logic [TotW-1:0] total;
    logic            in_xfer, out_xfer;
    logic [AddrW-1:0] idx_addr, last_addr;
    logic [CntW-1:0]  n_m1;

    assign cur_cnt  = r_pool ? r_cnt1 : r_cnt0;
    assign total    = TotW'(r_cnt0) + TotW'(r_cnt1);
    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = r_ovalid && i_ready;
    assign idx_addr = {r_pool, r_idx[IdxW-1:0]};
    assign n_m1     = r_n - 1'b1;
    assign last_addr = {r_pool, n_m1[IdxW-1:0]};

    assign o_ready = (r_state == ST_IDLE) && !r_ovalid;

    always_comb begin
        n_state   = r_state;
        n_pool    = r_pool;
        n_cnt0    = r_cnt0;
        n_cnt1    = r_cnt1;
        n_idx     = r_idx;
        n_n       = r_n;
        n_dead    = r_dead;
        n_work    = r_work;
        n_ovalid  = r_ovalid && !i_ready;
        n_ostatus = r_ostatus;
        n_opool   = r_opool;
        n_opv     = r_opv;
        n_olast   = r_olast;
        n_opx     = r_opx;
        n_opy     = r_opy;
        n_opz     = r_opz;
        n_oqx     = r_oqx;
        n_oqy     = r_oqy;
        n_oqz     = r_oqz;
        mem_we    = 1'b0;
        mem_waddr = idx_addr;
        mem_wdata = r_work;
        mem_raddr = idx_addr;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_pool = i_pool_select;
                    n_idx  = '0;
                    case (t_req'(i_req_type))
                        REQ_SPAWN:   n_state = ST_SPAWN;
                        REQ_TICK: begin
                            n_pool  = 1'b0;
                            n_state = ST_T_RD;
                        end
                        REQ_READOUT: begin
                            n_pool  = 1'b0;
                            n_state = ST_R_RD;
                        end
                        default:     n_state = ST_RESP;
                    endcase
                end
            end

            ST_SPAWN: begin
                n_ostatus = 1'b1;
                if (cur_cnt < CntW'(POOL_DEPTH)) begin
                    mem_we           = 1'b1;
                    mem_waddr        = {r_pool, cur_cnt[IdxW-1:0]};
                    mem_wdata.life   = cfg_life;
                    mem_wdata.pos_x  = r_ipx;
                    mem_wdata.pos_y  = r_ipy;
                    mem_wdata.pos_z  = r_ipz;
                    mem_wdata.prev_x = r_ipx;
                    mem_wdata.prev_y = r_ipy;
                    mem_wdata.prev_z = r_ipz;
                    mem_wdata.vel_x  = r_ivx;
                    mem_wdata.vel_y  = r_ivy;
                    mem_wdata.vel_z  = r_ivz;
                    if (r_pool) n_cnt1 = r_cnt1 + 1'b1;
                    else        n_cnt0 = r_cnt0 + 1'b1;
                    n_ostatus = 1'b0;
                end
                n_opool  = 1'b0;
                n_opv    = 1'b0;
                n_olast  = 1'b1;
                n_opx = '0; n_opy = '0; n_opz = '0;
                n_oqx = '0; n_oqy = '0; n_oqz = '0;
                n_ovalid = 1'b1;
                n_state  = ST_IDLE;
            end

            // Tick, stepping phase.
            ST_T_RD: begin
                if (r_idx < cur_cnt) begin
                    n_state = ST_T_WAIT;
                end else begin
                    n_idx   = '0;
                    n_n     = cur_cnt;
                    n_state = ST_C_RD;
                end
            end
            ST_T_WAIT: begin
                n_work = mem_rdata;
                n_dead[r_idx[IdxW-1:0]] = ($signed(mem_rdata.life) <= 0);
                n_state = ST_T_VEL;
            end
            ST_T_VEL: begin
                n_work.life   = sat34(34'($signed(r_work.life)) - 34'(r_dt));
                n_work.prev_x = r_work.pos_x;
                n_work.prev_y = r_work.pos_y;
                n_work.prev_z = r_work.pos_z;
                n_work.vel_x  = sat34(34'($signed(r_work.vel_x)) + 34'(mul_dt(cfg_px, r_dt)));
                n_work.vel_y  = sat34(34'($signed(r_work.vel_y)) + 34'(mul_dt(cfg_py, r_dt)));
                n_work.vel_z  = sat34(34'($signed(r_work.vel_z)) + 34'(mul_dt(cfg_pz, r_dt)));
                n_state = ST_T_POS;
            end
            ST_T_POS: begin
                n_work.pos_x = sat34(34'($signed(r_work.pos_x))
                                     + 34'(mul_dt(r_work.vel_x, r_dt)));
                n_work.pos_y = sat34(34'($signed(r_work.pos_y))
                                     + 34'(mul_dt(r_work.vel_y, r_dt)));
                n_work.pos_z = sat34(34'($signed(r_work.pos_z))
                                     + 34'(mul_dt(r_work.vel_z, r_dt)));
                n_state = ST_T_WR;
            end
            ST_T_WR: begin
                mem_we  = !r_dead[r_idx[IdxW-1:0]];
                n_idx   = r_idx + 1'b1;
                n_state = ST_T_RD;
            end

            // Tick, compaction: swap the last entry into each hole and recheck it.
            ST_C_RD: begin
                if (r_idx < r_n) begin
                    if (!r_dead[r_idx[IdxW-1:0]]) begin
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_n = n_m1;
                        if (r_idx == n_m1) begin
                            n_state = ST_C_RD;
                        end else begin
                            n_dead[r_idx[IdxW-1:0]] = r_dead[n_m1[IdxW-1:0]];
                            n_state = ST_C_WAIT;
                        end
                    end
                end else begin
                    if (r_pool) n_cnt1 = r_n;
                    else        n_cnt0 = r_n;
                    n_idx = '0;
                    if (!r_pool) begin
                        n_pool  = 1'b1;
                        n_state = ST_T_RD;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
                mem_raddr = last_addr;
            end
            ST_C_WAIT: begin
                n_work  = mem_rdata;
                n_state = ST_C_CPY;
            end
            ST_C_CPY: begin
                mem_we  = 1'b1;
                n_state = ST_C_CHK;
            end
            ST_C_CHK: begin
                n_state = ST_C_RD;
            end

            // Readout: walk pool 0 then pool 1.
            ST_R_RD: begin
                if (total == '0) begin
                    n_state = ST_RESP;
                end else if (r_idx < cur_cnt) begin
                    n_state = ST_R_WAIT;
                end else begin
                    n_pool = 1'b1;
                    n_idx  = '0;
                end
            end
            ST_R_WAIT: begin
                n_work  = mem_rdata;
                n_state = ST_R_OUT;
            end
            ST_R_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = 1'b0;
                    n_opool   = r_pool;
                    n_opv     = 1'b1;
                    n_olast   = r_pool ? (r_idx + 1'b1 == r_cnt1)
                                       : (r_idx + 1'b1 == r_cnt0 && r_cnt1 == '0);
                    n_opx = r_work.pos_x;  n_opy = r_work.pos_y;  n_opz = r_work.pos_z;
                    n_oqx = r_work.prev_x; n_oqy = r_work.prev_y; n_oqz = r_work.prev_z;
                    n_idx = r_idx + 1'b1;
                    if (n_olast) n_state = ST_IDLE;
                    else         n_state = ST_R_RD;
                end
            end

            ST_RESP: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = 1'b0;
                    n_opool   = 1'b0;
                    n_opv     = 1'b0;
                    n_olast   = 1'b1;
                    n_opx = '0; n_opy = '0; n_opz = '0;
                    n_oqx = '0; n_oqy = '0; n_oqz = '0;
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt0   <= '0;
            r_cnt1   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt0   <= n_cnt0;
            r_cnt1   <= n_cnt1;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pool    <= n_pool;
        r_idx     <= n_idx;
        r_n       <= n_n;
        r_dead    <= n_dead;
        r_work    <= n_work;
        r_ostatus <= n_ostatus;
        r_opool   <= n_opool;
        r_opv     <= n_opv;
        r_olast   <= n_olast;
        r_opx     <= n_opx;
        r_opy     <= n_opy;
        r_opz     <= n_opz;
        r_oqx     <= n_oqx;
        r_oqy     <= n_oqy;
        r_oqz     <= n_oqz;
        if (in_xfer) begin
            r_req <= t_req'(i_req_type);
            r_dt  <= i_step_time;
            r_ipx <= i_in_pos_x;
            r_ipy <= i_in_pos_y;
            r_ipz <= i_in_pos_z;
            r_ivx <= i_in_vel_x;
            r_ivy <= i_in_vel_y;
            r_ivz <= i_in_vel_z;
        end
    end

    // Live count follows the item's final state: counts are settled by the time any result shows.
    assign o_valid          = r_ovalid;
    assign o_status         = r_ostatus && (r_req == REQ_SPAWN);
    assign o_out_pool       = r_opool;
    assign o_out_pos_x      = r_opx;
    assign o_out_pos_y      = r_opy;
    assign o_out_pos_z      = r_opz;
    assign o_out_prev_x     = r_oqx;
    assign o_out_prev_y     = r_oqy;
    assign o_out_prev_z     = r_oqz;
    assign o_live_count     = 7'(total);
    assign o_particle_valid = r_opv;
    assign o_last           = r_olast;

endmodule

@@ design/ppeu_cfg_regs.sv @@
// Configuration register file: lifetimes and per-pool acceleration.
module ppeu_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ppeu_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [ppeu_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                          i_pool,
    output logic [31:0]                   o_life,
    output logic [31:0]                   o_pull_x,
    output logic [31:0]                   o_pull_y,
    output logic [31:0]                   o_pull_z
);
    import ppeu_pkg::*;

    logic [30:0] r_life0, r_life1;
    logic [31:0] r_px0, r_py0, r_pz0, r_px1, r_py1, r_pz1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life0 <= LifePool0Rst;
            r_life1 <= LifePool1Rst;
            r_px0   <= '0;
            r_py0   <= '0;
            r_pz0   <= '0;
            r_px1   <= '0;
            r_py1   <= PullY1Rst;
            r_pz1   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LIFE0: r_life0 <= i_cfg_data[30:0];
                CFG_LIFE1: r_life1 <= i_cfg_data[30:0];
                CFG_PX0:   r_px0   <= i_cfg_data;
                CFG_PY0:   r_py0   <= i_cfg_data;
                CFG_PZ0:   r_pz0   <= i_cfg_data;
                CFG_PX1:   r_px1   <= i_cfg_data;
                CFG_PY1:   r_py1   <= i_cfg_data;
                CFG_PZ1:   r_pz1   <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    assign o_life   = {1'b0, (i_pool ? r_life1 : r_life0)};
    assign o_pull_x = i_pool ? r_px1 : r_px0;
    assign o_pull_y = i_pool ? r_py1 : r_py0;
    assign o_pull_z = i_pool ? r_pz1 : r_pz0;

endmodule

@@ design/ppeu_part_mem.sv @@
// Particle store: one row per particle, one write and one registered read per cycle.
module ppeu_part_mem #(
    parameter int unsigned Depth = 64,
    parameter int unsigned AddrW = 6
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AddrW-1:0]     i_waddr,
    input  ppeu_pkg::t_part      i_wdata,
    input  logic [AddrW-1:0]     i_raddr,
    output ppeu_pkg::t_part      o_rdata
);
    import ppeu_pkg::*;

    t_part r_mem [Depth];
    t_part r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ppeu_checker.sv @@
// Port-level checks for the particle pool update block, bound to the top level.
module ppeu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_status,
    input logic        o_particle_valid,
    input logic        o_last,
    input logic [6:0]  o_live_count,
    input logic [31:0] o_out_pos_x
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_pos_x))
        else $error("result changed while stalled");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while a result is pending");

    a_status_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_particle_valid && o_last)
        else $error("full status on a particle result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_live_count <= 7'd64)
        else $error("live count out of range");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_particle_valid |-> o_out_pos_x == 32'd0)
        else $error("position shown without a particle");

endmodule

bind particle_pool_euler_update_top ppeu_checker u_ppeu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_particle_valid (o_particle_valid),
    .o_last           (o_last),
    .o_live_count     (o_live_count),
    .o_out_pos_x      (o_out_pos_x)
);

@@ tb/particle_pool_euler_update_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the two-pool Euler particle update block.
module particle_pool_euler_update_top_tb;
    import ppeu_pkg::*;

    localparam int POOLS_N   = 2;
    localparam int DEPTH     = 32;
    localparam int SLOTS     = 64;
    localparam int STALL_MAX = 20000;   // cycles with no transfer before giving up
    localparam int SETTLE    = 40;      // idle cycles after the last result

    // One stored particle as the bench mirrors it.
    typedef struct {
        logic signed [31:0] life;
        logic signed [31:0] pos[3];
        logic signed [31:0] prev[3];
        logic signed [31:0] vel[3];
    } particle_t;

    // One request on the input channel.
    typedef struct {
        t_req               req;
        logic               pool;
        logic signed [31:0] pos[3];
        logic signed [31:0] vel[3];
        logic [15:0]        dt;
    } request_t;

    // One response on the output channel.
    typedef struct {
        logic               status;
        logic               pool;
        logic signed [31:0] pos[3];
        logic signed [31:0] prev[3];
        logic [6:0]         live;
        logic               pvalid;
        logic               last;
    } response_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = REQ_NONE;
    logic        i_pool_select = 1'b0;
    logic [31:0] i_in_pos_x = '0, i_in_pos_y = '0, i_in_pos_z = '0;
    logic [31:0] i_in_vel_x = '0, i_in_vel_y = '0, i_in_vel_z = '0;
    logic [15:0] i_step_time = '0;
    logic        i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b1;
    logic        o_status, o_out_pool, o_particle_valid, o_last;
    logic [31:0] o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic [31:0] o_out_prev_x, o_out_prev_y, o_out_prev_z;
    logic [6:0]  o_live_count;

    particle_pool_euler_update_top dut (.*);

    always #2 i_clk = ~i_clk;

    // Mirror of the block state and registers.
    particle_t          store_m[SLOTS];
    int unsigned        count_m[POOLS_N];
    logic [30:0]        lifetime_m[POOLS_N];
    logic signed [31:0] pull_m[POOLS_N][3];

    response_t expected_q[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        no_idle = 1'b0;   // last stretch: both sides stream

    //------------------------------------------------------------------
    // Fixed-point helpers
    //------------------------------------------------------------------
    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Q16.16 * Q0.16, floored back to Q16.16
    function automatic longint times_dt(logic signed [31:0] a, logic [15:0] dt);
        longint p;
        p = longint'(a) * longint'({48'd0, dt});
        return p >>> 16;
    endfunction

    function automatic void mirror_reset();
        lifetime_m[0] = LifePool0Rst;
        lifetime_m[1] = LifePool1Rst;
        foreach (pull_m[p, a]) pull_m[p][a] = '0;
        pull_m[1][1] = PullY1Rst;
        count_m[0] = 0;
        count_m[1] = 0;
    endfunction

    function automatic void push_response(logic st, logic pool, int slot, logic pv,
                                          logic lst);
        response_t r;
        r.status = st;
        r.pool   = pool;
        for (int a = 0; a < 3; a++) begin
            r.pos[a]  = pv ? store_m[slot].pos[a]  : '0;
            r.prev[a] = pv ? store_m[slot].prev[a] : '0;
        end
        r.live   = 7'(count_m[0] + count_m[1]);
        r.pvalid = pv;
        r.last   = lst;
        expected_q.push_back(r);
    endfunction

    // Euler step of one pool, then removal of what was already expired.
    function automatic void advance_pool(int p, logic [15:0] dt);
        bit expired[DEPTH];
        int base, n, i, k;
        base = p * DEPTH;
        n = count_m[p];
        for (i = 0; i < n; i++) begin
            k = base + i;
            expired[i] = store_m[k].life <= 0;
            if (!expired[i]) begin
                store_m[k].life = clamp32(longint'(store_m[k].life) - longint'(dt));
                for (int a = 0; a < 3; a++) begin
                    store_m[k].prev[a] = store_m[k].pos[a];
                    store_m[k].vel[a] = clamp32(longint'(store_m[k].vel[a])
                                                + times_dt(pull_m[p][a], dt));
                    store_m[k].pos[a] = clamp32(longint'(store_m[k].pos[a])
                                                + times_dt(store_m[k].vel[a], dt));
                end
            end
        end
        // hole filled from the tail; the moved entry is looked at again
        i = 0;
        while (i < n) begin
            if (!expired[i]) begin
                i++;
            end else begin
                n--;
                if (i != n) begin
                    store_m[base + i] = store_m[base + n];
                    expired[i] = expired[n];
                end
            end
        end
        count_m[p] = n;
    endfunction

    function automatic void predict_request(request_t rq);
        int total, n;
        case (rq.req)
            REQ_SPAWN: begin
                if (count_m[rq.pool] < DEPTH) begin
                    int k;
                    k = rq.pool * DEPTH + count_m[rq.pool];
                    store_m[k].pos  = rq.pos;
                    store_m[k].prev = rq.pos;
                    store_m[k].vel  = rq.vel;
                    store_m[k].life = {1'b0, lifetime_m[rq.pool]};
                    count_m[rq.pool]++;
                    push_response(1'b0, 1'b0, 0, 1'b0, 1'b1);
                end else begin
                    push_response(1'b1, 1'b0, 0, 1'b0, 1'b1);
                end
            end
            REQ_TICK: begin
                advance_pool(0, rq.dt);
                advance_pool(1, rq.dt);
                push_response(1'b0, 1'b0, 0, 1'b0, 1'b1);
            end
            REQ_READOUT: begin
                total = count_m[0] + count_m[1];
                n = 0;
                if (total == 0) push_response(1'b0, 1'b0, 0, 1'b0, 1'b1);
                for (int q = 0; q < POOLS_N; q++) begin
                    for (int i = 0; i < count_m[q]; i++) begin
                        n++;
                        push_response(1'b0, 1'(q), q * DEPTH + i, 1'b1, n == total);
                    end
                end
            end
            default: push_response(1'b0, 1'b0, 0, 1'b0, 1'b1);
        endcase
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------
    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic request_t make_request(t_req req, logic pool, logic [15:0] dt);
        request_t rq;
        rq.req  = req;
        rq.pool = pool;
        rq.dt   = dt;
        for (int a = 0; a < 3; a++) begin
            rq.pos[a] = pick_coord();
            rq.vel[a] = pick_coord();
        end
        return rq;
    endfunction

    // Drives one request and waits for its transfer; valid stays up afterwards.
    task automatic send_request(request_t rq);
        bit taken;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= rq.req;
        i_pool_select <= rq.pool;
        i_in_pos_x    <= rq.pos[0];
        i_in_pos_y    <= rq.pos[1];
        i_in_pos_z    <= rq.pos[2];
        i_in_vel_x    <= rq.vel[0];
        i_in_vel_y    <= rq.vel[1];
        i_in_vel_z    <= rq.vel[2];
        i_step_time   <= rq.dt;
        // ready is looked at mid-cycle, where nothing moves
        do begin
            @(negedge i_clk);
            taken = o_ready && i_valid;
            @(posedge i_clk);
        end while (!taken);
        predict_request(rq);
    endtask

    task automatic send_kind(t_req req, logic pool, logic [15:0] dt);
        send_request(make_request(req, pool, dt));
    endtask

    // Drain the block, then write one register.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_LIFE0: lifetime_m[0] = value[30:0];
            CFG_LIFE1: lifetime_m[1] = value[30:0];
            CFG_PX0:   pull_m[0][0]  = value;
            CFG_PY0:   pull_m[0][1]  = value;
            CFG_PZ0:   pull_m[0][2]  = value;
            CFG_PX1:   pull_m[1][0]  = value;
            CFG_PY1:   pull_m[1][1]  = value;
            default:   pull_m[1][2]  = value;
        endcase
    endtask

    //------------------------------------------------------------------
    // Response side: ready bursts, checking, watchdog
    //------------------------------------------------------------------
    int ready_hold = 0;
    always @(posedge i_clk) begin
        if (no_idle || !i_rst_n) begin
            i_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_ready    <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(0, 16);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Sampled mid-cycle: a valid/ready pair seen here transfers at the next edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((o_valid && i_ready) || (i_valid && o_ready) || i_cfg_we) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_MAX) begin
                $display("CHECKS FAILED");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transfer at %0t", $realtime);
                end else begin
                    response_t e;
                    e = expected_q.pop_front();
                    if (o_status !== e.status || o_out_pool !== e.pool
                        || o_out_pos_x !== e.pos[0] || o_out_pos_y !== e.pos[1]
                        || o_out_pos_z !== e.pos[2] || o_out_prev_x !== e.prev[0]
                        || o_out_prev_y !== e.prev[1] || o_out_prev_z !== e.prev[2]
                        || o_live_count !== e.live || o_particle_valid !== e.pvalid
                        || o_last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  exp st=%0d pool=%0d pos=%h %h %h prev=%h %h %h live=%0d pv=%0d last=%0d",
                                     e.status, e.pool, e.pos[0], e.pos[1], e.pos[2],
                                     e.prev[0], e.prev[1], e.prev[2], e.live, e.pvalid, e.last);
                            $display("  got st=%0d pool=%0d pos=%h %h %h prev=%h %h %h live=%0d pv=%0d last=%0d",
                                     o_status, o_out_pool, o_out_pos_x, o_out_pos_y,
                                     o_out_pos_z, o_out_prev_x, o_out_prev_y, o_out_prev_z,
                                     o_live_count, o_particle_valid, o_last);
                        end
                    end
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    // Empty pools: readout, unused request code, zero-length tick.
    task automatic test_empty_pools();
        send_kind(REQ_READOUT, 1'b0, 16'd0);
        send_kind(REQ_NONE, 1'b1, 16'hFFFF);
        send_kind(REQ_TICK, 1'b0, 16'd0);
        send_kind(REQ_READOUT, 1'b1, 16'd0);
    endtask

    // Field extremes, saturation on a full-length tick.
    task automatic test_field_extremes();
        request_t rq;
        rq = make_request(REQ_SPAWN, 1'b0, 16'd0);
        foreach (rq.pos[a]) begin
            rq.pos[a] = 32'sh7FFF_FFFF;
            rq.vel[a] = 32'sh7FFF_FFFF;
        end
        send_request(rq);
        rq.pool = 1'b1;
        foreach (rq.pos[a]) begin
            rq.pos[a] = 32'sh8000_0000;
            rq.vel[a] = 32'sh8000_0000;
        end
        rq.dt = 16'hFFFF;
        send_request(rq);
        rq.pool = 1'b0;
        foreach (rq.pos[a]) begin
            rq.pos[a] = '0;
            rq.vel[a] = '0;
        end
        send_request(rq);
        send_kind(REQ_READOUT, 1'b0, 16'd0);
        send_kind(REQ_TICK, 1'b1, 16'hFFFF);
        send_kind(REQ_READOUT, 1'b0, 16'd0);
        send_kind(REQ_TICK, 1'b0, 16'd0);
        send_kind(REQ_NONE, 1'b0, 16'd0);
        send_kind(REQ_READOUT, 1'b0, 16'd0);
    endtask

    // Zero lifetime: removal at the first tick, tail entries moved and rechecked.
    task automatic test_expiry();
        write_reg(CFG_LIFE0, 32'd0);
        repeat (3) send_kind(REQ_SPAWN, 1'b0, 16'd0);
        write_reg(CFG_LIFE0, 32'hFFFF_FFFF);
        send_kind(REQ_SPAWN, 1'b0, 16'd0);
        write_reg(CFG_LIFE0, 32'd0);
        send_kind(REQ_SPAWN, 1'b0, 16'd0);
        send_kind(REQ_TICK, 1'b0, 16'd100);
        send_kind(REQ_READOUT, 1'b0, 16'd0);
        send_kind(REQ_TICK, 1'b0, 16'd100);
        send_kind(REQ_READOUT, 1'b0, 16'd0);
    endtask

    // One pool past its depth; the other keeps accepting.
    task automatic test_pool_full();
        write_reg(CFG_LIFE1, 32'h0004_0000);
        repeat (DEPTH + 2) send_kind(REQ_SPAWN, 1'b1, 16'd0);
        send_kind(REQ_SPAWN, 1'b0, 16'd0);
        send_kind(REQ_READOUT, 1'b0, 16'd0);
    endtask

    // Random traffic under a given register set.
    task automatic test_random_phase(int items, bit extreme);
        write_reg(CFG_LIFE0, extreme ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0003_0000));
        write_reg(CFG_LIFE1, extreme ? 32'h8000_0000 | $urandom
                                     : $urandom_range(0, 32'h0004_0000));
        for (int r = CFG_PX0; r <= CFG_PZ1; r++) begin
            logic [31:0] v;
            case ($urandom_range(0, 3))
                0:       v = extreme ? 32'h8000_0000 : $urandom;
                1:       v = extreme ? 32'h7FFF_FFFF : '0;
                default: v = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            endcase
            write_reg(t_cfg_idx'(r), v);
        end
        for (int n = 0; n < items; n++) begin
            int roll;
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                send_kind(REQ_SPAWN, 1'($urandom), 16'd0);
            end else if (roll < 80) begin
                send_kind(REQ_TICK, 1'($urandom),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 16'h3000)));
            end else if (roll < 96) begin
                send_kind(REQ_READOUT, 1'($urandom), 16'($urandom));
            end else begin
                send_kind(REQ_NONE, 1'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        mirror_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pools();
        test_field_extremes();
        test_expiry();
        test_pool_full();
        test_random_phase(90, 1'b0);
        test_random_phase(80, 1'b1);
        test_random_phase(90, 1'b0);
        test_random_phase(80, 1'b0);
        no_idle = 1'b1;
        test_random_phase(70, 1'b1);

        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/ppeu_pkg.sv
design/ppeu_cfg_regs.sv
design/ppeu_part_mem.sv
design/particle_pool_euler_update_top.sv
design/ppeu_checker.sv
tb/particle_pool_euler_update_top_tb.sv
